FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the cube ifs child point generator
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: src/cifs_pkg.sv
// ----------------------------------------------------------------------------
// cifs_pkg
// constants, types and tables of the cube ifs child point generator
// ----------------------------------------------------------------------------
`default_nettype none

package cifs_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_SUBCUBES  = 8;
   localparam int NUM_SYMS      = 48;
   localparam int MAP_W         = 6;
   localparam int SUB_W         = 3;

   typedef logic [MAP_W-1:0] map_type;
   typedef logic [SUB_W-1:0] sub_type;

   localparam map_type MAP_RESET [NUM_SUBCUBES] = '{
      map_type'(48), map_type'(0), map_type'(0), map_type'(48),
      map_type'(0), map_type'(48), map_type'(48), map_type'(0)
   };

   // one output coordinate: source column and sign
   typedef struct packed {
      logic       neg;
      logic [1:0] src;
   } sym_term_type;

   typedef struct packed {
      sym_term_type z;
      sym_term_type y;
      sym_term_type x;
   } sym_row_type;

   typedef enum logic [1:0] {
      COL_ZERO  = 2'd0,
      COL_ONE   = 2'd1,
      COL_HALF  = 2'd2,
      COL_FIFTH = 2'd3
   } colour_code_type;

   typedef struct packed {
      colour_code_type b;
      colour_code_type g;
      colour_code_type r;
   } cube_colour_type;

   function automatic sym_term_type mk_term(input int r);
      sym_term_type t;
      t.neg = (r < 0);
      t.src = 2'(((r < 0) ? -r : r) - 1);
      return t;
   endfunction

   function automatic sym_row_type mk_row(input int a, input int b, input int c);
      sym_row_type row;
      row.x = mk_term(a);
      row.y = mk_term(b);
      row.z = mk_term(c);
      return row;
   endfunction

   // octahedral symmetry elements as signed permutations
   function automatic sym_row_type sym_rows(input map_type s);
      sym_row_type row;
      unique case (s)
         6'd0:  row = mk_row( 1,  2,  3);
         6'd1:  row = mk_row( 2,  1,  3);
         6'd2:  row = mk_row( 1,  3,  2);
         6'd3:  row = mk_row( 2,  3,  1);
         6'd4:  row = mk_row( 3,  1,  2);
         6'd5:  row = mk_row( 3,  2,  1);
         6'd6:  row = mk_row(-2, -1,  3);
         6'd7:  row = mk_row(-1, -2,  3);
         6'd8:  row = mk_row(-3, -1,  2);
         6'd9:  row = mk_row(-3, -2,  1);
         6'd10: row = mk_row(-1, -3,  2);
         6'd11: row = mk_row(-2, -3,  1);
         6'd12: row = mk_row(-2,  3, -1);
         6'd13: row = mk_row(-1,  3, -2);
         6'd14: row = mk_row(-3,  2, -1);
         6'd15: row = mk_row(-3,  1, -2);
         6'd16: row = mk_row(-1,  2, -3);
         6'd17: row = mk_row(-2,  1, -3);
         6'd18: row = mk_row( 3, -2, -1);
         6'd19: row = mk_row( 3, -1, -2);
         6'd20: row = mk_row( 2, -3, -1);
         6'd21: row = mk_row( 1, -3, -2);
         6'd22: row = mk_row( 2, -1, -3);
         6'd23: row = mk_row( 1, -2, -3);
         6'd24: row = mk_row(-1, -2, -3);
         6'd25: row = mk_row(-2, -1, -3);
         6'd26: row = mk_row(-1, -3, -2);
         6'd27: row = mk_row(-2, -3, -1);
         6'd28: row = mk_row(-3, -1, -2);
         6'd29: row = mk_row(-3, -2, -1);
         6'd30: row = mk_row( 2,  1, -3);
         6'd31: row = mk_row( 1,  2, -3);
         6'd32: row = mk_row( 3,  1, -2);
         6'd33: row = mk_row( 3,  2, -1);
         6'd34: row = mk_row( 1,  3, -2);
         6'd35: row = mk_row( 2,  3, -1);
         6'd36: row = mk_row( 2, -3,  1);
         6'd37: row = mk_row( 1, -3,  2);
         6'd38: row = mk_row( 3, -2,  1);
         6'd39: row = mk_row( 3, -1,  2);
         6'd40: row = mk_row( 1, -2,  3);
         6'd41: row = mk_row( 2, -1,  3);
         6'd42: row = mk_row(-3,  2,  1);
         6'd43: row = mk_row(-3,  1,  2);
         6'd44: row = mk_row(-2,  3,  1);
         6'd45: row = mk_row(-1,  3,  2);
         6'd46: row = mk_row(-2,  1,  3);
         6'd47: row = mk_row(-1,  2,  3);
         default: row = mk_row(1, 2, 3);
      endcase
      return row;
   endfunction

   // octant corner sign, 1 means -1
   function automatic logic corner_neg(input sub_type k, input logic [1:0] axis);
      logic n;
      unique case (axis)
         2'd0:    n = ~k[0];
         2'd1:    n = ~k[2];
         default: n = k[1];
      endcase
      return n;
   endfunction

   function automatic cube_colour_type cube_colour(input sub_type k);
      cube_colour_type c;
      unique case (k)
         3'd0: c = '{b: COL_ZERO,  g: COL_ONE,   r: COL_ZERO};
         3'd1: c = '{b: COL_FIFTH, g: COL_FIFTH, r: COL_FIFTH};
         3'd2: c = '{b: COL_ZERO,  g: COL_ZERO,  r: COL_ONE};
         3'd3: c = '{b: COL_ZERO,  g: COL_ONE,   r: COL_ONE};
         3'd4: c = '{b: COL_ONE,   g: COL_ZERO,  r: COL_ONE};
         3'd5: c = '{b: COL_ONE,   g: COL_ONE,   r: COL_ONE};
         3'd6: c = '{b: COL_ONE,   g: COL_ZERO,  r: COL_ZERO};
         default: c = '{b: COL_ONE, g: COL_HALF, r: COL_ONE};
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: src/cube_ifs_child_point_generator.sv
// a parent transfer loads the parent and pending mask registers, from which
// each child is computed and written to the result register; one child per cycle
// while the result register is not stalled, set by the single child arithmetic unit
// the next parent transfers in the cycle its last child enters the result register
// reset: clears the pending subcube mask and result valid, loads the map registers
// ----------------------------------------------------------------------------
// cube_ifs_child_point_generator
// expands a parent point into the children of its enabled subcubes, in order
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cube_ifs_child_point_generator #(
   parameter int FRAC_BITS = cifs_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // parent_x, parent_y, parent_z, parent_past_r, parent_past_g, parent_past_b
   input  logic [((6*FRAC_BITS+16)/8)*8-1:0] req_tdata,
   // is_root
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // child_x, child_y, child_z, cube_r, cube_g, cube_b, past_r, past_g, past_b
   output logic [((9*FRAC_BITS+19)/8)*8-1:0] rsp_tdata,
   // subcube
   output cifs_pkg::sub_type                 rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  cifs_pkg::sub_type                 csr_addr,
   input  cifs_pkg::map_type                 csr_wdata
);
   import cifs_pkg::*;

   localparam int CW     = FRAC_BITS + 2;
   localparam int LW     = FRAC_BITS + 1;

   map_type map_ff [NUM_SUBCUBES];
   map_type map_in [NUM_SUBCUBES];

   logic [NUM_SUBCUBES-1:0] pend_ff, pend_in, pend_next, en_mask, sel_oh;
   sub_type                 sel_idx;

   logic signed [CW-1:0] coord_ff [3];
   logic signed [CW-1:0] coord_in [3];
   logic        [LW-1:0] ppast_ff [3];
   logic        [LW-1:0] ppast_in [3];
   logic                 root_ff, root_in;

   logic signed [CW-1:0] child_ff [3];
   logic signed [CW-1:0] child_in [3];
   logic        [LW-1:0] cube_ff  [3];
   logic        [LW-1:0] cube_in  [3];
   logic        [LW-1:0] past_ff  [3];
   logic        [LW-1:0] past_in  [3];
   sub_type              sub_ff, sub_in;
   logic                 last_ff, last_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic advance, req_fire;

   // lowest pending subcube
   always_comb begin
      sel_idx = '0;
      for (int i = NUM_SUBCUBES - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel_idx = SUB_W'(i);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_SUBCUBES; k++) begin
         en_mask[k] = (map_ff[k] < MAP_W'(NUM_SYMS));
      end
   end

   assign sel_oh     = pend_ff & (~pend_ff + 1'b1);
   assign pend_next  = pend_ff & ~sel_oh;
   assign advance    = (pend_ff != '0) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (pend_ff == '0) || (advance && (pend_next == '0));
   assign req_fire   = req_tvalid && req_tready;

   cifs_child #(
      .FRAC_BITS (FRAC_BITS)
   ) u_child (
      .parent  (coord_ff),
      .ppast   (ppast_ff),
      .is_root (root_ff),
      .sym     (map_ff[sel_idx]),
      .sub     (sel_idx),
      .child   (child_in),
      .cube    (cube_in),
      .past    (past_in)
   );

   assign sub_in  = sel_idx;
   assign last_in = (pend_next == '0);

   always_comb begin
      map_in = map_ff;
      if (csr_we) begin
         map_in[csr_addr] = csr_wdata;
      end
   end

   always_comb begin
      pend_in  = pend_ff;
      coord_in = coord_ff;
      ppast_in = ppast_ff;
      root_in  = root_ff;
      if (req_fire) begin
         pend_in = en_mask;
         for (int j = 0; j < 3; j++) begin
            coord_in[j] = req_tdata[j*CW +: CW];
            ppast_in[j] = req_tdata[3*CW + j*LW +: LW];
         end
         root_in = req_tuser;
      end else if (advance) begin
         pend_in = pend_next;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff       <= MAP_RESET;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         map_ff       <= map_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coord_ff <= coord_in;
      ppast_ff <= ppast_in;
      root_ff  <= root_in;
      if (advance) begin
         child_ff <= child_in;
         cube_ff  <= cube_in;
         past_ff  <= past_in;
         sub_ff   <= sub_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int j = 0; j < 3; j++) begin
         rsp_tdata[j*CW +: CW]                = child_ff[j];
         rsp_tdata[3*CW + j*LW +: LW]         = cube_ff[j];
         rsp_tdata[3*CW + 3*LW + j*LW +: LW]  = past_ff[j];
      end
   end

   assign rsp_tuser  = sub_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // pending subcubes hold while the result register is stalled
   `ASSERT_NEXT(a_pend_hold, clock, reset,
      (pend_ff != '0) && rsp_valid_ff && !rsp_tready, $stable(pend_ff))
   // a child moved forward is presented next cycle
   `ASSERT_NEXT(a_adv_valid, clock, reset, advance, rsp_valid_ff)
   // after the last child with no new parent, nothing is pending
   `ASSERT_NEXT(a_drain, clock, reset,
      advance && (pend_next == '0) && !req_fire, pend_ff == '0)
   `ASSERT_IMPL(a_sel_onehot, clock, reset, pend_ff != '0, $onehot(sel_oh))

endmodule

`default_nettype wire

FILE: src/cifs_child.sv
// ----------------------------------------------------------------------------
// cifs_child
// child point and colour arithmetic for one subcube of one parent
// ----------------------------------------------------------------------------
`default_nettype none

module cifs_child #(
   parameter int FRAC_BITS = cifs_pkg::FRAC_BITS_DEF
) (
   input  logic signed [FRAC_BITS+1:0] parent [3],
   input  logic        [FRAC_BITS:0]   ppast  [3],
   input  logic                        is_root,
   input  cifs_pkg::map_type           sym,
   input  cifs_pkg::sub_type           sub,
   output logic signed [FRAC_BITS+1:0] child  [3],
   output logic        [FRAC_BITS:0]   cube   [3],
   output logic        [FRAC_BITS:0]   past   [3]
);
   import cifs_pkg::*;

   localparam int CW = FRAC_BITS + 2;
   localparam int LW = FRAC_BITS + 1;

   localparam logic signed [CW:0] HALF_C = (CW+1)'(longint'(1) << (FRAC_BITS - 1));
   localparam logic [LW-1:0] COL_ONE_V   = LW'(longint'(1) << FRAC_BITS);
   localparam logic [LW-1:0] COL_HALF_V  = LW'(longint'(1) << (FRAC_BITS - 1));
   localparam logic [LW-1:0] COL_FIFTH_V = LW'(((longint'(2) << FRAC_BITS) + 5) / 10);

   sym_row_type     row;
   sym_term_type    term [3];
   cube_colour_type ccode;
   colour_code_type code [3];

   function automatic logic [LW-1:0] colour_value(input colour_code_type c);
      logic [LW-1:0] v;
      unique case (c)
         COL_ONE:   v = COL_ONE_V;
         COL_HALF:  v = COL_HALF_V;
         COL_FIFTH: v = COL_FIFTH_V;
         default:   v = '0;
      endcase
      return v;
   endfunction

   assign row     = sym_rows(sym);
   assign term[0] = row.x;
   assign term[1] = row.y;
   assign term[2] = row.z;

   assign ccode   = cube_colour(sub);
   assign code[0] = ccode.r;
   assign code[1] = ccode.g;
   assign code[2] = ccode.b;

   always_comb begin
      logic signed [CW-1:0] src;
      logic signed [CW:0]   v;
      logic signed [CW:0]   half;
      logic signed [CW:0]   sum;
      logic        [LW:0]   csum;
      for (int j = 0; j < 3; j++) begin
         unique case (term[j].src)
            2'd0:    src = parent[0];
            2'd1:    src = parent[1];
            default: src = parent[2];
         endcase
         v    = term[j].neg ? -(CW+1)'(src) : (CW+1)'(src);
         half = v >>> 1;
         sum  = half + (corner_neg(sub, 2'(j)) ? -HALF_C : HALF_C);
         child[j] = sum[CW-1:0];

         cube[j] = colour_value(code[j]);
         csum    = {1'b0, ppast[j]} + {1'b0, cube[j]};
         past[j] = is_root ? cube[j] : csum[LW:1];
      end
   end

endmodule

`default_nettype wire

FILE: tb/cube_ifs_child_point_generator_test.sv
// ----------------------------------------------------------------------------
// cube_ifs_child_point_generator_test
// self-checking bench: directed table, then random parents over map settings
// each child transfer checked field by field, in order, under random idling,
// one long receiver hold-off and one drain pause
// ----------------------------------------------------------------------------
`default_nettype none

module cube_ifs_child_point_generator_test;

   import cifs_pkg::*;

   localparam int FB      = FRAC_BITS_DEF;
   localparam int COORD_W = FB + 2;
   localparam int COL_W   = FB + 1;
   localparam int REQ_W   = ((6*FB+16)/8)*8;
   localparam int RSP_W   = ((9*FB+19)/8)*8;
   localparam int LIMIT   = 400000;
   localparam int DIR_ROWS = 18;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic signed [COORD_W-1:0] x, y, z;
      logic [COL_W-1:0]          pr, pg, pb;
      logic                      root;
   } parent_type;

   typedef struct {
      logic signed [COORD_W-1:0] cx, cy, cz;
      logic [COL_W-1:0]          cr, cg, cb;
      logic [COL_W-1:0]          qr, qg, qb;
      sub_type                   sub;
      logic                      last;
   } child_type;

   typedef struct {
      int grp;
      int x, y, z, pr, pg, pb, root;
      int typed;
      int cx, cy, cz, qr, qg, qb;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   // parent_x, parent_y, parent_z, parent_past_r, parent_past_g, parent_past_b
   logic [REQ_W-1:0] req_tdata = '0;
   // is_root
   logic             req_tuser = 1'b0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // child_x, child_y, child_z, cube_r, cube_g, cube_b, past_r, past_g, past_b
   logic [RSP_W-1:0] rsp_tdata;
   // subcube
   sub_type          rsp_tuser;
   logic             rsp_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic             csr_we = 1'b0;
   sub_type          csr_addr = '0;
   map_type          csr_wdata = '0;

   cube_ifs_child_point_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // signed permutation rows: +-(source axis + 1) per output axis
   int perm_tab [0:143] = '{
       1, 2, 3,   2, 1, 3,   1, 3, 2,   2, 3, 1,   3, 1, 2,   3, 2, 1,
      -2,-1, 3,  -1,-2, 3,  -3,-1, 2,  -3,-2, 1,  -1,-3, 2,  -2,-3, 1,
      -2, 3,-1,  -1, 3,-2,  -3, 2,-1,  -3, 1,-2,  -1, 2,-3,  -2, 1,-3,
       3,-2,-1,   3,-1,-2,   2,-3,-1,   1,-3,-2,   2,-1,-3,   1,-2,-3,
      -1,-2,-3,  -2,-1,-3,  -1,-3,-2,  -2,-3,-1,  -3,-1,-2,  -3,-2,-1,
       2, 1,-3,   1, 2,-3,   3, 1,-2,   3, 2,-1,   1, 3,-2,   2, 3,-1,
       2,-3, 1,   1,-3, 2,   3,-2, 1,   3,-1, 2,   1,-2, 3,   2,-1, 3,
      -3, 2, 1,  -3, 1, 2,  -2, 3, 1,  -1, 3, 2,  -2, 1, 3,  -1, 2, 3
   };

   int octant_tab [0:23] = '{
      -1,-1, 1,   1,-1, 1,  -1,-1,-1,   1,-1,-1,
      -1, 1, 1,   1, 1, 1,  -1, 1,-1,   1, 1,-1
   };

   colour_code_type hue_tab [0:23] = '{
      COL_ZERO,  COL_ONE,   COL_ZERO,
      COL_FIFTH, COL_FIFTH, COL_FIFTH,
      COL_ONE,   COL_ZERO,  COL_ZERO,
      COL_ONE,   COL_ONE,   COL_ZERO,
      COL_ONE,   COL_ZERO,  COL_ONE,
      COL_ONE,   COL_ONE,   COL_ONE,
      COL_ZERO,  COL_ZERO,  COL_ONE,
      COL_ONE,   COL_HALF,  COL_ONE
   };

   // grp 0 reset maps, grp 1 only subcube 5 identity, grp 2 all on, grp 3 all off
   dir_row_type dir_tab [DIR_ROWS] = '{
      '{0,       0,       0,       0,      0,      0,      0, 1, 0, 0,0,0,0,0,0},
      '{0,   65536,   65536,   65536,  65536,  65536,  65536, 0, 0, 0,0,0,0,0,0},
      '{0,  -65536,  -65536,  -65536,      0,      0,      0, 0, 0, 0,0,0,0,0,0},
      '{0,   65536,  -65536,       0, 131071,      0,  65536, 0, 0, 0,0,0,0,0,0},
      '{0, -131072,  131071,      -1, 131071, 131071, 131071, 1, 0, 0,0,0,0,0,0},
      '{0,       1,      -1,   12345,    100,    200,    300, 0, 0, 0,0,0,0,0,0},
      '{1,       0,       0,       0,    777,    777,    777, 1, 1,
        32768, 32768, 32768, 65536, 65536, 65536},
      '{1,   65536,   65536,   65536,      0,      0,      0, 0, 1,
        65536, 65536, 65536, 32768, 32768, 32768},
      '{1,  -65536,  -65536,  -65536,  65536,  65536,  65536, 0, 1,
        0, 0, 0, 65536, 65536, 65536},
      '{1,   65536,  -65536,       0,      0,  65536,      0, 0, 1,
        65536, 0, 32768, 32768, 65536, 32768},
      // odd negatives halve toward minus infinity
      '{1,      -1,       1,      -3,      1,      3,  65535, 0, 1,
        32767, 32768, 32766, 32768, 32769, 65535},
      // coordinates and colours beyond one
      '{1,  131071, -131072,       0, 131071, 131071,      0, 0, 1,
        98303, -32768, 32768, 98303, 98303, 32768},
      '{1,       0,       0,       0, 131071, 131071, 131071, 1, 1,
        32768, 32768, 32768, 65536, 65536, 65536},
      '{2,   65536,  -65536,       1,      0,  65536, 131071, 0, 0, 0,0,0,0,0,0},
      '{2,      -1,      -3,       5,      1,      1,      1, 1, 0, 0,0,0,0,0,0},
      '{2, -131072, -131072, -131072,      0,      0,      0, 0, 0, 0,0,0,0,0,0},
      // no subcube enabled
      '{3,      12,      34,      56,    100,    100,    100, 0, 0, 0,0,0,0,0,0},
      '{3,  -65536,   65536,       0,  65536,      0,  65536, 1, 0, 0,0,0,0,0,0}
   };

   map_type map_shadow [NUM_SUBCUBES] = '{
      map_type'(48), map_type'(0), map_type'(0), map_type'(48),
      map_type'(0), map_type'(48), map_type'(48), map_type'(0)
   };
   map_type map_plan [NUM_SUBCUBES];

   child_type children_due [$];
   int errors = 0;
   int cycle_count = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [COL_W-1:0] hue_level(input colour_code_type code);
      logic [COL_W-1:0] one;
      one = COL_W'(1) << FB;
      case (code)
         COL_ONE:   return one;
         COL_HALF:  return one >> 1;
         COL_FIFTH: return COL_W'((2*(1 << FB) + 5) / 10);
         default:   return '0;
      endcase
   endfunction

   task automatic expand_parent(input parent_type p);
      longint pv [3];
      longint v, c;
      logic signed [COORD_W-1:0] pt [3];
      logic [COL_W-1:0] par [3];
      logic [COL_W-1:0] hue [3];
      logic [COL_W-1:0] inh [3];
      int final_k, code, src;
      child_type ch;
      pv[0] = p.x;
      pv[1] = p.y;
      pv[2] = p.z;
      par[0] = p.pr;
      par[1] = p.pg;
      par[2] = p.pb;
      final_k = -1;
      for (int k = 0; k < NUM_SUBCUBES; k++)
         if (map_shadow[k] < NUM_SYMS) final_k = k;
      for (int k = 0; k < NUM_SUBCUBES; k++) begin
         if (map_shadow[k] >= NUM_SYMS) continue;
         for (int j = 0; j < 3; j++) begin
            code = perm_tab[int'(map_shadow[k])*3 + j];
            src = ((code < 0) ? -code : code) - 1;
            v = (code < 0) ? -pv[src] : pv[src];
            c = (v >>> 1) + longint'(octant_tab[k*3 + j]) * (longint'(1) << (FB - 1));
            pt[j] = COORD_W'(c);
            hue[j] = hue_level(hue_tab[k*3 + j]);
            inh[j] = p.root ? hue[j] : COL_W'(((COL_W+1)'(par[j]) + hue[j]) >> 1);
         end
         ch.cx = pt[0];
         ch.cy = pt[1];
         ch.cz = pt[2];
         ch.cr = hue[0];
         ch.cg = hue[1];
         ch.cb = hue[2];
         ch.qr = inh[0];
         ch.qg = inh[1];
         ch.qb = inh[2];
         ch.sub = sub_type'(k);
         ch.last = (k == final_k);
         children_due.push_back(ch);
      end
   endtask

   function automatic parent_type rand_parent();
      parent_type p;
      int sel;
      int pick [3];
      sel = $urandom_range(99);
      for (int j = 0; j < 3; j++) begin
         if (sel < 12) begin
            pick[j] = int'($urandom_range((1 << COORD_W) - 1)) - (1 << (COORD_W - 1));
         end else if (sel < 25) begin
            case ($urandom_range(4))
               0:       pick[j] = -65536;
               1:       pick[j] = 0;
               2:       pick[j] = 65536;
               3:       pick[j] = -1;
               default: pick[j] = 1;
            endcase
         end else begin
            pick[j] = int'($urandom_range(131072)) - 65536;
         end
      end
      p.x = COORD_W'(pick[0]);
      p.y = COORD_W'(pick[1]);
      p.z = COORD_W'(pick[2]);
      if (sel < 12) begin
         p.pr = COL_W'($urandom);
         p.pg = COL_W'($urandom);
         p.pb = COL_W'($urandom);
      end else if (sel < 25) begin
         p.pr = $urandom_range(1) ? COL_W'(65536) : '0;
         p.pg = $urandom_range(1) ? COL_W'(65536) : '0;
         p.pb = $urandom_range(1) ? COL_W'(65536) : '0;
      end else begin
         p.pr = COL_W'($urandom_range(65536));
         p.pg = COL_W'($urandom_range(65536));
         p.pb = COL_W'($urandom_range(65536));
      end
      p.root = ($urandom_range(3) == 0);
      return p;
   endfunction

   task automatic send_parent(input parent_type p);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= REQ_W'({p.pb, p.pg, p.pr, p.z, p.y, p.x});
      req_tuser  <= p.root;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (children_due.size() != 0);
   endtask

   // block is idle once every child is in and a no-result parent has cleared
   task automatic settle();
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);
   endtask

   task automatic load_maps();
      for (int k = 0; k < NUM_SUBCUBES; k++) begin
         csr_we    <= 1'b1;
         csr_addr  <= sub_type'(k);
         csr_wdata <= map_plan[k];
         map_shadow[k] = map_plan[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic plan_group(input int g);
      for (int k = 0; k < NUM_SUBCUBES; k++) begin
         case (g)
            1:       map_plan[k] = (k == 5) ? map_type'(0) : map_type'(48);
            2:       map_plan[k] = map_type'((k * 6) % NUM_SYMS + ((k == 1) ? 41 : 0));
            default: map_plan[k] = map_type'(48 + (k * 5) % 16);
         endcase
      end
   endtask

   task automatic plan_segment(input int seg);
      for (int k = 0; k < NUM_SUBCUBES; k++) begin
         if (seg < 6)
            map_plan[k] = map_type'((seg * 8 + k) % NUM_SYMS);
         else if (seg == 6)
            map_plan[k] = map_type'(48 + $urandom_range(15));
         else if (seg == 7)
            map_plan[k] = map_type'(0);
         else if (seg == 8)
            map_plan[k] = map_type'(NUM_SYMS - 1);
         else if ($urandom_range(99) < 60)
            map_plan[k] = map_type'($urandom_range(NUM_SYMS - 1));
         else
            map_plan[k] = map_type'(48 + $urandom_range(15));
      end
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin : child_monitor
      child_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.cx = rsp_tdata[17:0];
         got.cy = rsp_tdata[35:18];
         got.cz = rsp_tdata[53:36];
         got.cr = rsp_tdata[70:54];
         got.cg = rsp_tdata[87:71];
         got.cb = rsp_tdata[104:88];
         got.qr = rsp_tdata[121:105];
         got.qg = rsp_tdata[138:122];
         got.qb = rsp_tdata[155:139];
         got.sub = rsp_tuser;
         got.last = rsp_tlast;
         if (children_due.size() == 0) begin
            $error("child transfer with no expected child waiting");
            errors++;
         end else begin
            want = children_due.pop_front();
            check_field("child_x", want.cx, got.cx);
            check_field("child_y", want.cy, got.cy);
            check_field("child_z", want.cz, got.cz);
            check_field("cube_r", want.cr, got.cr);
            check_field("cube_g", want.cg, got.cg);
            check_field("cube_b", want.cb, got.cb);
            check_field("past_r", want.qr, got.qr);
            check_field("past_g", want.qg, got.qg);
            check_field("past_b", want.qb, got.qb);
            check_field("subcube", want.sub, got.sub);
            check_field("last", want.last, got.last);
         end
      end
   end

   initial begin : stimulus
      parent_type p;
      child_type ch;
      int grp_now;
      int count;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle = 13;
      recv_idle = 82;
      grp_now = 0;
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (dir_tab[r].grp != grp_now) begin
            grp_now = dir_tab[r].grp;
            settle();
            plan_group(grp_now);
            load_maps();
         end
         p.x = COORD_W'(dir_tab[r].x);
         p.y = COORD_W'(dir_tab[r].y);
         p.z = COORD_W'(dir_tab[r].z);
         p.pr = COL_W'(dir_tab[r].pr);
         p.pg = COL_W'(dir_tab[r].pg);
         p.pb = COL_W'(dir_tab[r].pb);
         p.root = dir_tab[r].root[0];
         send_parent(p);
         if (dir_tab[r].typed != 0) begin
            ch.cx = COORD_W'(dir_tab[r].cx);
            ch.cy = COORD_W'(dir_tab[r].cy);
            ch.cz = COORD_W'(dir_tab[r].cz);
            ch.cr = COL_W'(65536);
            ch.cg = COL_W'(65536);
            ch.cb = COL_W'(65536);
            ch.qr = COL_W'(dir_tab[r].qr);
            ch.qg = COL_W'(dir_tab[r].qg);
            ch.qb = COL_W'(dir_tab[r].qb);
            ch.sub = sub_type'(5);
            ch.last = 1'b1;
            children_due.push_back(ch);
         end else begin
            expand_parent(p);
         end
      end
      for (int seg = 0; seg < 12; seg++) begin
         if (seg == 4) begin
            send_idle = 82;
            recv_idle = 13;
         end else if (seg == 8) begin
            send_idle = 0;
            recv_idle = 0;
         end
         settle();
         plan_segment(seg);
         load_maps();
         count = (seg == 6) ? 10 : 31;
         for (int i = 0; i < count; i++) begin
            if (seg == 8 && i == 5) hold_asks++;
            if (seg == 9 && i == 15) begin
               req_tvalid <= 1'b0;
               wait_drained();
            end
            p = rand_parent();
            send_parent(p);
            expand_parent(p);
         end
      end
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
